FILE: sv/rkrso_pkg.sv
// Shared types and constants for the ring key range set operations block.
package rkrso_pkg;

    localparam int unsigned PORT_KEY_BITS = 64;
    localparam int unsigned MODE_BITS     = 3;
    localparam int unsigned COUNT_BITS    = 2;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_KEY_IN    = 3'd0,
        MODE_INSIDE    = 3'd1,
        MODE_OVERLAP   = 3'd2,
        MODE_UNION     = 3'd3,
        MODE_DIFF      = 3'd4,
        MODE_INTERSECT = 3'd5,
        MODE_INVERT    = 3'd6
    } mode_t;

    localparam logic [COUNT_BITS-1:0] PIECES_NONE = 2'd0;
    localparam logic [COUNT_BITS-1:0] PIECES_ONE  = 2'd1;
    localparam logic [COUNT_BITS-1:0] PIECES_TWO  = 2'd2;

endpackage

FILE: sv/ring_key_range_set_ops_top.sv
// Ring key range set operations: registered input, single-pass logic, registered result.
//
// One transfer is taken on every clock edge at which start is high; busy is never raised,
// so items may follow each other in consecutive cycles, one item per cycle. The compare
// and subtract logic sits between the input register and the result register. Each item
// produces exactly one result, shown for one cycle with done high: done and the result
// registers are loaded at the same edge from the input register, so done comes with its
// result. The receiver cannot hold results off.
// Keys are reduced to their low KEY_WIDTH bits; result keys are zero-extended to 64 bits.
module ring_key_range_set_ops_top #(
    parameter int unsigned KEY_WIDTH = 64
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic [rkrso_pkg::MODE_BITS-1:0]            mode,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0]        a_min,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0]        a_max,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0]        b_min,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0]        b_max,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0]        probe_key,
    output logic                                       done,
    output logic                                       flag,
    output logic [rkrso_pkg::COUNT_BITS-1:0]           piece_count,
    output logic [rkrso_pkg::PORT_KEY_BITS-1:0]        first_min,
    output logic [rkrso_pkg::PORT_KEY_BITS-1:0]        first_max,
    output logic [rkrso_pkg::PORT_KEY_BITS-1:0]        second_min,
    output logic [rkrso_pkg::PORT_KEY_BITS-1:0]        second_max
);

    localparam int unsigned KW = KEY_WIDTH;
    localparam logic [KW-1:0] KEY_ONE  = KW'(1);
    localparam logic [KW-1:0] KEY_ZERO = '0;
    localparam logic [KW-1:0] KEY_MAX  = '1;

    typedef struct packed {
        logic [KW-1:0] lo;
        logic [KW-1:0] hi;
    } rng_t;

    typedef struct packed {
        logic ok;
        rng_t r;
    } comb_t;

    typedef struct packed {
        logic [rkrso_pkg::COUNT_BITS-1:0] cnt;
        rng_t                             p1;
        rng_t                             p2;
    } diff_t;

    function automatic logic is_full(rng_t r);
        logic [KW-1:0] nxt;
        nxt = r.hi + KEY_ONE;
        return nxt == r.lo;
    endfunction

    function automatic logic key_in(logic [KW-1:0] k, rng_t r);
        logic res;
        if (r.hi >= r.lo)
        begin
            res = (k >= r.lo) && (k <= r.hi);
        end
        else
        begin
            res = (k >= r.lo) || (k <= r.hi);
        end
        return res;
    endfunction

    function automatic rng_t invert(rng_t r);
        rng_t o;
        o.lo = r.hi + KEY_ONE;
        o.hi = r.lo - KEY_ONE;
        return o;
    endfunction

    function automatic logic range_inside(rng_t outer, rng_t inner);
        logic [KW-1:0] span;
        logic [KW-1:0] dl;
        logic [KW-1:0] dh;
        logic          res;
        span = outer.hi - outer.lo;
        dl   = inner.lo - outer.lo;
        dh   = inner.hi - outer.lo;
        if (is_full(outer))
        begin
            res = 1'b1;
        end
        else
        begin
            res = !(dh < dl) && !(span < dl) && !(span < dh);
        end
        return res;
    endfunction

    function automatic comb_t combine(rng_t x, rng_t y);
        comb_t         res;
        rng_t          s;
        rng_t          t;
        logic [KW-1:0] d_xy;
        logic [KW-1:0] d_yx;
        logic [KW-1:0] sp_x;
        logic [KW-1:0] sp_y;
        logic [KW-1:0] s_span;
        logic [KW-1:0] t_hi_off;
        res  = '0;
        d_xy = y.lo - x.lo;
        sp_x = x.hi - x.lo;
        d_yx = x.lo - y.lo;
        sp_y = y.hi - y.lo;
        if (d_xy > sp_x)
        begin
            s = y;
            t = x;
        end
        else
        begin
            s = x;
            t = y;
        end
        s_span   = s.hi - s.lo;
        t_hi_off = t.hi - s.lo;
        if (is_full(x))
        begin
            res.ok = 1'b1;
            res.r  = x;
        end
        else if (is_full(y))
        begin
            res.ok = 1'b1;
            res.r  = y;
        end
        else if ((d_xy > sp_x) && (d_yx > sp_y))
        begin
            res.ok = 1'b0;
        end
        else if (range_inside(t, invert(s)))
        begin
            res.ok = 1'b1;
            res.r  = '{lo: KEY_ZERO, hi: KEY_MAX};
        end
        else if (s_span < t_hi_off)
        begin
            res.ok = 1'b1;
            res.r  = '{lo: s.lo, hi: t.hi};
        end
        else
        begin
            res.ok = 1'b1;
            res.r  = s;
        end
        return res;
    endfunction

    function automatic diff_t difference(rng_t a, rng_t b);
        diff_t         res;
        logic [KW-1:0] aspan;
        logic [KW-1:0] bl;
        logic [KW-1:0] bh;
        logic [KW-1:0] b_after;
        logic [KW-1:0] b_before;
        res      = '0;
        aspan    = a.hi - a.lo;
        bl       = b.lo - a.lo;
        bh       = b.hi - a.lo;
        b_after  = b.hi + KEY_ONE;
        b_before = b.lo - KEY_ONE;
        if (is_full(b))
        begin
            res.cnt = rkrso_pkg::PIECES_NONE;
        end
        else if (bh < bl)
        begin
            if (aspan > bh)
            begin
                res.cnt   = rkrso_pkg::PIECES_ONE;
                res.p1.lo = b_after;
                res.p1.hi = (aspan < bl) ? a.hi : b_before;
            end
        end
        else if (aspan < bl)
        begin
            res.cnt = rkrso_pkg::PIECES_ONE;
            res.p1  = a;
        end
        else if (a.lo == b.lo)
        begin
            if (aspan > bh)
            begin
                res.cnt = rkrso_pkg::PIECES_ONE;
                res.p1  = '{lo: b_after, hi: a.hi};
            end
        end
        else
        begin
            res.p1 = '{lo: a.lo, hi: b_before};
            if (aspan <= bh)
            begin
                res.cnt = rkrso_pkg::PIECES_ONE;
            end
            else
            begin
                res.cnt = rkrso_pkg::PIECES_TWO;
                res.p2  = '{lo: b_after, hi: a.hi};
            end
        end
        return res;
    endfunction

    logic                                 in_valid_reg;
    logic [rkrso_pkg::MODE_BITS-1:0]      mode_reg;
    rng_t                                 a_reg;
    rng_t                                 b_reg;
    logic [KW-1:0]                        probe_reg;

    logic                                 done_reg;
    logic                                 flag_reg;
    logic [rkrso_pkg::COUNT_BITS-1:0]     count_reg;
    rng_t                                 p1_reg;
    rng_t                                 p2_reg;

    logic                                 flag_next;
    logic [rkrso_pkg::COUNT_BITS-1:0]     count_next;
    rng_t                                 p1_next;
    rng_t                                 p2_next;

    comb_t                                uni;
    diff_t                                dif;
    diff_t                                isect;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg  <= mode;
            a_reg     <= '{lo: a_min[KW-1:0], hi: a_max[KW-1:0]};
            b_reg     <= '{lo: b_min[KW-1:0], hi: b_max[KW-1:0]};
            probe_reg <= probe_key[KW-1:0];
        end
    end

    always_comb
    begin
        uni   = combine(a_reg, b_reg);
        dif   = difference(a_reg, b_reg);
        isect = difference(a_reg, invert(b_reg));
    end

    always_comb
    begin
        flag_next  = 1'b1;
        count_next = rkrso_pkg::PIECES_NONE;
        p1_next    = '0;
        p2_next    = '0;
        unique case (rkrso_pkg::mode_t'(mode_reg))
            rkrso_pkg::MODE_KEY_IN:
            begin
                flag_next = key_in(probe_reg, a_reg);
            end
            rkrso_pkg::MODE_INSIDE:
            begin
                flag_next = range_inside(a_reg, b_reg);
            end
            rkrso_pkg::MODE_OVERLAP:
            begin
                flag_next = is_full(b_reg) || !range_inside(a_reg, invert(b_reg));
            end
            rkrso_pkg::MODE_UNION:
            begin
                if (uni.ok)
                begin
                    count_next = rkrso_pkg::PIECES_ONE;
                    p1_next    = uni.r;
                end
                else
                begin
                    count_next = rkrso_pkg::PIECES_TWO;
                    p1_next    = a_reg;
                    p2_next    = b_reg;
                end
            end
            rkrso_pkg::MODE_DIFF:
            begin
                count_next = dif.cnt;
                p1_next    = dif.p1;
                p2_next    = dif.p2;
            end
            rkrso_pkg::MODE_INTERSECT:
            begin
                if (is_full(b_reg))
                begin
                    count_next = rkrso_pkg::PIECES_ONE;
                    p1_next    = a_reg;
                end
                else
                begin
                    count_next = isect.cnt;
                    p1_next    = isect.p1;
                    p2_next    = isect.p2;
                end
            end
            rkrso_pkg::MODE_INVERT:
            begin
                if (!is_full(a_reg))
                begin
                    count_next = rkrso_pkg::PIECES_ONE;
                    p1_next    = invert(a_reg);
                end
            end
            default:
            begin
                flag_next = 1'b0;
            end
        endcase
        if (count_next != rkrso_pkg::PIECES_TWO)
        begin
            p2_next = '0;
        end
        if (count_next == rkrso_pkg::PIECES_NONE)
        begin
            p1_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            flag_reg  <= flag_next;
            count_reg <= count_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
        end
    end

    assign done        = done_reg;
    assign flag        = flag_reg;
    assign piece_count = count_reg;
    assign first_min   = rkrso_pkg::PORT_KEY_BITS'(p1_reg.lo);
    assign first_max   = rkrso_pkg::PORT_KEY_BITS'(p1_reg.hi);
    assign second_min  = rkrso_pkg::PORT_KEY_BITS'(p2_reg.lo);
    assign second_max  = rkrso_pkg::PORT_KEY_BITS'(p2_reg.hi);

endmodule

FILE: tb/sv/ring_key_range_set_ops_checker.sv
`timescale 1ns / 100ps
// Checker for the ring key range block: predicts each transfer's result and compares it.
module ring_key_range_set_ops_checker #(
    parameter int unsigned KEY_WIDTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [rkrso_pkg::MODE_BITS-1:0]     mode,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0] a_min,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0] a_max,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0] b_min,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0] b_max,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0] probe_key,
    input  logic                                done,
    input  logic                                flag,
    input  logic [rkrso_pkg::COUNT_BITS-1:0]    piece_count,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0] first_min,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0] first_max,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0] second_min,
    input  logic [rkrso_pkg::PORT_KEY_BITS-1:0] second_max,
    output int                                  fail_count,
    output int                                  checked_count,
    output int                                  outstanding
);

    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_WIDTH);

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } arc_t;

    typedef struct packed {
        logic                             flag;
        logic [rkrso_pkg::COUNT_BITS-1:0] count;
        arc_t                             first_arc;
        arc_t                             second_arc;
    } range_answer_t;

    range_answer_t expected_answers[$];
    int            mismatches = 0;
    int            compared   = 0;

    function automatic logic [63:0] ring_sub(logic [63:0] x, logic [63:0] y);
        return (x - y) & KEY_MASK;
    endfunction

    function automatic logic [63:0] ring_inc(logic [63:0] x);
        return (x + 64'd1) & KEY_MASK;
    endfunction

    function automatic bit is_whole(arc_t r);
        return ring_inc(r.hi) == r.lo;
    endfunction

    function automatic bit holds_key(logic [63:0] k, arc_t r);
        if (r.hi >= r.lo)
            return k >= r.lo && k <= r.hi;
        return k >= r.lo || k <= r.hi;
    endfunction

    function automatic bit encloses(arc_t outer, arc_t inner);
        logic [63:0] span;
        if (is_whole(outer))
            return 1'b1;
        span = ring_sub(outer.hi, outer.lo);
        if (ring_sub(inner.hi, outer.lo) < ring_sub(inner.lo, outer.lo))
            return 1'b0;
        if (span < ring_sub(inner.lo, outer.lo))
            return 1'b0;
        if (span < ring_sub(inner.hi, outer.lo))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic arc_t complement(arc_t r);
        arc_t o;
        o.lo = ring_inc(r.hi);
        o.hi = ring_sub(r.lo, 64'd1);
        return o;
    endfunction

    function automatic bit merge(arc_t x, arc_t y, output arc_t joined);
        arc_t s;
        arc_t t;
        s      = x;
        t      = y;
        joined = '0;
        if (is_whole(x))
        begin
            joined = x;
            return 1'b1;
        end
        if (is_whole(y))
        begin
            joined = y;
            return 1'b1;
        end
        if (ring_sub(t.lo, s.lo) > ring_sub(s.hi, s.lo))
        begin
            s = y;
            t = x;
            if (ring_sub(t.lo, s.lo) > ring_sub(s.hi, s.lo))
                return 1'b0;
        end
        if (encloses(t, complement(s)))
        begin
            joined.lo = '0;
            joined.hi = KEY_MASK;
        end
        else if (ring_sub(s.hi, s.lo) < ring_sub(t.hi, s.lo))
        begin
            joined.lo = s.lo;
            joined.hi = t.hi;
        end
        else
        begin
            joined = s;
        end
        return 1'b1;
    endfunction

    function automatic int subtract(arc_t a, arc_t b, output arc_t o1, output arc_t o2);
        logic [63:0] aspan;
        logic [63:0] bl;
        logic [63:0] bh;
        aspan = ring_sub(a.hi, a.lo);
        bl    = ring_sub(b.lo, a.lo);
        bh    = ring_sub(b.hi, a.lo);
        o1    = '0;
        o2    = '0;
        if (is_whole(b))
            return 0;
        if (bh < bl)
        begin
            if (aspan <= bh)
                return 0;
            o1.lo = ring_inc(b.hi);
            o1.hi = (aspan < bl) ? a.hi : ring_sub(b.lo, 64'd1);
            return 1;
        end
        if (aspan < bl)
        begin
            o1 = a;
            return 1;
        end
        if (a.lo == b.lo)
        begin
            if (aspan <= bh)
                return 0;
            o1.lo = ring_inc(b.hi);
            o1.hi = a.hi;
            return 1;
        end
        o1.lo = a.lo;
        o1.hi = ring_sub(b.lo, 64'd1);
        if (aspan <= bh)
            return 1;
        o2.lo = ring_inc(b.hi);
        o2.hi = a.hi;
        return 2;
    endfunction

    function automatic range_answer_t predict_range_op(logic [rkrso_pkg::MODE_BITS-1:0] op,
                                                       arc_t a, arc_t b, logic [63:0] key);
        range_answer_t r;
        arc_t          p1;
        arc_t          p2;
        int            n;
        bit            joined_ok;
        r  = '0;
        p1 = '0;
        p2 = '0;
        n  = 0;
        case (op)
            rkrso_pkg::MODE_KEY_IN:  r.flag = holds_key(key, a);
            rkrso_pkg::MODE_INSIDE:  r.flag = encloses(a, b);
            rkrso_pkg::MODE_OVERLAP: r.flag = is_whole(b) || !encloses(a, complement(b));
            rkrso_pkg::MODE_UNION:
            begin
                r.flag    = 1'b1;
                joined_ok = merge(a, b, p1);
                if (joined_ok)
                    n = 1;
                else
                begin
                    p1 = a;
                    p2 = b;
                    n  = 2;
                end
            end
            rkrso_pkg::MODE_DIFF:
            begin
                r.flag = 1'b1;
                n      = subtract(a, b, p1, p2);
            end
            rkrso_pkg::MODE_INTERSECT:
            begin
                r.flag = 1'b1;
                if (is_whole(b))
                begin
                    p1 = a;
                    n  = 1;
                end
                else
                    n = subtract(a, complement(b), p1, p2);
            end
            rkrso_pkg::MODE_INVERT:
            begin
                r.flag = 1'b1;
                if (!is_whole(a))
                begin
                    p1 = complement(a);
                    n  = 1;
                end
            end
            default: ;
        endcase
        r.count = n[rkrso_pkg::COUNT_BITS-1:0];
        if (n >= 1)
            r.first_arc = p1;
        if (n >= 2)
            r.second_arc = p2;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch_transfers
        range_answer_t want;
        arc_t          arc_a;
        arc_t          arc_b;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("result transfer with no request awaiting it");
                    mismatches++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    check_field("flag", 64'(want.flag), 64'(flag));
                    check_field("piece_count", 64'(want.count), 64'(piece_count));
                    check_field("first_min", want.first_arc.lo, first_min);
                    check_field("first_max", want.first_arc.hi, first_max);
                    check_field("second_min", want.second_arc.lo, second_min);
                    check_field("second_max", want.second_arc.hi, second_max);
                    compared++;
                end
            end
            if (start && !busy)
            begin
                arc_a.lo = a_min & KEY_MASK;
                arc_a.hi = a_max & KEY_MASK;
                arc_b.lo = b_min & KEY_MASK;
                arc_b.hi = b_max & KEY_MASK;
                expected_answers.push_back(
                    predict_range_op(mode, arc_a, arc_b, probe_key & KEY_MASK));
            end
        end
        fail_count    <= mismatches;
        checked_count <= compared;
        outstanding   <= expected_answers.size();
    end

endmodule

FILE: tb/sv/ring_key_range_set_ops_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the ring key range block: clock, reset, stimulus and verdict.
module ring_key_range_set_ops_top_tb;

    localparam int unsigned     KEY_WIDTH    = 64;
    localparam int              RANDOM_ITEMS = 1850;
    localparam int              CYCLE_LIMIT  = 200000;
    localparam logic [63:0]     KEY_TOP      = {64{1'b1}};
    localparam logic [rkrso_pkg::MODE_BITS-1:0] MODE_UNUSED = 3'd7;

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 start     = 1'b0;
    logic                                 busy;
    logic [rkrso_pkg::MODE_BITS-1:0]      mode      = '0;
    logic [rkrso_pkg::PORT_KEY_BITS-1:0]  a_min     = '0;
    logic [rkrso_pkg::PORT_KEY_BITS-1:0]  a_max     = '0;
    logic [rkrso_pkg::PORT_KEY_BITS-1:0]  b_min     = '0;
    logic [rkrso_pkg::PORT_KEY_BITS-1:0]  b_max     = '0;
    logic [rkrso_pkg::PORT_KEY_BITS-1:0]  probe_key = '0;
    logic                                 done;
    logic                                 flag;
    logic [rkrso_pkg::COUNT_BITS-1:0]     piece_count;
    logic [rkrso_pkg::PORT_KEY_BITS-1:0]  first_min;
    logic [rkrso_pkg::PORT_KEY_BITS-1:0]  first_max;
    logic [rkrso_pkg::PORT_KEY_BITS-1:0]  second_min;
    logic [rkrso_pkg::PORT_KEY_BITS-1:0]  second_max;

    int fail_count;
    int checked_count;
    int outstanding;
    int cycles          = 0;
    int items_sent      = 0;
    int sender_idle_pct = 0;

    ring_key_range_set_ops_top #(
        .KEY_WIDTH(KEY_WIDTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .a_min      (a_min),
        .a_max      (a_max),
        .b_min      (b_min),
        .b_max      (b_max),
        .probe_key  (probe_key),
        .done       (done),
        .flag       (flag),
        .piece_count(piece_count),
        .first_min  (first_min),
        .first_max  (first_max),
        .second_min (second_min),
        .second_max (second_max)
    );

    ring_key_range_set_ops_checker #(
        .KEY_WIDTH(KEY_WIDTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .a_min        (a_min),
        .a_max        (a_max),
        .b_min        (b_min),
        .b_max        (b_max),
        .probe_key    (probe_key),
        .done         (done),
        .flag         (flag),
        .piece_count  (piece_count),
        .first_min    (first_min),
        .first_max    (first_max),
        .second_min   (second_min),
        .second_max   (second_max),
        .fail_count   (fail_count),
        .checked_count(checked_count),
        .outstanding  (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] nudge(logic [63:0] base);
        return base + 64'($urandom_range(15)) - 64'd8;
    endfunction

    function automatic logic [63:0] any_key();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input logic [rkrso_pkg::MODE_BITS-1:0] op,
                             input logic [63:0] amin,
                             input logic [63:0] amax, input logic [63:0] bmin,
                             input logic [63:0] bmax, input logic [63:0] key);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        mode      <= op;
        a_min     <= amin;
        a_max     <= amax;
        b_min     <= bmin;
        b_max     <= bmax;
        probe_key <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic random_ranges(output logic [63:0] amin, output logic [63:0] amax,
                                 output logic [63:0] bmin, output logic [63:0] bmax,
                                 output logic [63:0] key);
        logic [63:0] anchor;
        case ($urandom_range(2))
            0:       anchor = '0;
            1:       anchor = KEY_TOP - 64'd7;
            default: anchor = any_key();
        endcase
        amin = any_key();
        amax = any_key();
        bmin = any_key();
        bmax = any_key();
        case ($urandom_range(9))
            2, 3, 4:
            begin
                amin = nudge(anchor);
                amax = nudge(anchor);
                bmin = nudge(anchor);
                bmax = nudge(anchor);
            end
            5: amax = amin - 64'd1;
            6: bmax = bmin - 64'd1;
            7:
            begin
                bmin = nudge(amin);
                bmax = nudge(amax);
            end
            8:
            begin
                if ($urandom_range(1))
                    bmin = amax + 64'd1;
                else
                    bmax = amin - 64'd1;
            end
            9: bmin = amin;
            default: ;
        endcase
        if ($urandom_range(1))
            key = nudge($urandom_range(1) ? amin : amax);
        else
            key = any_key();
    endtask

    task automatic run_random(input int count);
        logic [rkrso_pkg::MODE_BITS-1:0] op;
        logic [63:0]                     amin;
        logic [63:0]                     amax;
        logic [63:0]                     bmin;
        logic [63:0]                     bmax;
        logic [63:0]                     key;
        repeat (count)
        begin
            op = rkrso_pkg::MODE_BITS'($urandom_range(7));
            random_ranges(amin, amax, bmin, bmax, key);
            send_item(op, amin, amax, bmin, bmax, key);
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 19;
        send_item(rkrso_pkg::MODE_KEY_IN, 64'd10, 64'd20, '0, '0, 64'd10);
        send_item(rkrso_pkg::MODE_KEY_IN, 64'd10, 64'd20, '0, '0, 64'd21);
        send_item(rkrso_pkg::MODE_KEY_IN, KEY_TOP - 64'd1, 64'd1, '0, '0, '0);
        send_item(rkrso_pkg::MODE_KEY_IN, 64'd5, 64'd4, '0, '0, KEY_TOP);
        send_item(rkrso_pkg::MODE_KEY_IN, '0, '0, '0, '0, '0);
        send_item(rkrso_pkg::MODE_INSIDE, 64'd7, 64'd6, KEY_TOP - 64'd3, 64'd2, '0);
        send_item(rkrso_pkg::MODE_INSIDE, KEY_TOP - 64'd9, 64'd9, KEY_TOP - 64'd2, 64'd3, '0);
        send_item(rkrso_pkg::MODE_INSIDE, '0, 64'd100, 64'd50, 64'd150, '0);
        send_item(rkrso_pkg::MODE_OVERLAP, 64'd10, 64'd20, 64'd3, 64'd2, '0);
        send_item(rkrso_pkg::MODE_OVERLAP, 64'd10, 64'd20, 64'd21, 64'd30, '0);
        send_item(rkrso_pkg::MODE_OVERLAP, 64'd10, 64'd20, 64'd20, 64'd30, '0);
        send_item(rkrso_pkg::MODE_UNION, 64'd10, 64'd20, 64'd21, 64'd30, '0);
        send_item(rkrso_pkg::MODE_UNION, 64'd10, 64'd20, 64'd15, 64'd12, '0);
        send_item(rkrso_pkg::MODE_UNION, 64'd10, 64'd20, 64'd40, 64'd50, '0);
        send_item(rkrso_pkg::MODE_UNION, 64'd10, 64'd20, '0, KEY_TOP, '0);
        send_item(rkrso_pkg::MODE_DIFF, 64'd10, 64'd20, 64'd9, 64'd8, '0);
        send_item(rkrso_pkg::MODE_DIFF, '0, 64'd100, 64'd40, 64'd60, '0);
        send_item(rkrso_pkg::MODE_DIFF, 64'd10, 64'd20, 64'd10, 64'd15, '0);
        send_item(rkrso_pkg::MODE_DIFF, 64'd10, 64'd20, 64'd18, 64'd12, '0);
        send_item(rkrso_pkg::MODE_INTERSECT, 64'd10, 64'd20, 64'd1, '0, '0);
        send_item(rkrso_pkg::MODE_INTERSECT, 64'd10, 64'd20, 64'd30, 64'd40, '0);
        send_item(rkrso_pkg::MODE_INTERSECT, KEY_TOP - 64'd5, 64'd5, '0, 64'd100, '0);
        send_item(rkrso_pkg::MODE_INVERT, 64'd3, 64'd2, '0, '0, '0);
        send_item(rkrso_pkg::MODE_INVERT, KEY_TOP, KEY_TOP, '0, '0, '0);
        send_item(MODE_UNUSED, KEY_TOP, KEY_TOP, KEY_TOP, KEY_TOP, KEY_TOP);
        hold_until_drained();

        run_random(620);
        hold_until_drained();
        sender_idle_pct = 86;
        run_random(620);
        hold_until_drained();
        sender_idle_pct = 0;
        run_random(RANDOM_ITEMS - 1240);
        hold_until_drained();
        repeat (6)
            @(posedge clk);

        $display("Covered %0d transfers: 25 directed edge cases, the rest random over all",
                 items_sent);
        $display("modes and the unused code; %0d results compared at three sender gap rates",
                 checked_count);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: ring_key_range_set_ops_top.f
sv/rkrso_pkg.sv
sv/ring_key_range_set_ops_top.sv
tb/sv/ring_key_range_set_ops_checker.sv
tb/sv/ring_key_range_set_ops_top_tb.sv
